/* hdl/caeu_pkg.sv */
package caeu_pkg;

	localparam int MAX_DATA_GROUPS_DEF = 72;
	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int GROUP_COUNT_W = 7;
	localparam logic [GROUP_COUNT_W-1:0] GROUP_COUNT_MAX = '1;

	localparam logic [39:0] CHECKSUM_INIT = 40'd1;
	localparam logic [39:0] GEN [5] = '{
		40'h98f2bc8e61, 40'h79b76d99e2, 40'hf33e5fb3c4, 40'hae2eabe2a8, 40'h1e4f43e470
	};
	localparam logic [255:0] SYMBOL_STR = "qpzry9x8gf2tvdw0s3jn54khce6mua7l";
	localparam logic [7:0] SEPARATOR = 8'h3a;
	localparam logic [2:0] STEP_LAST = 3'd7;

	typedef enum logic {
		KIND_PREFIX  = 1'b0,
		KIND_PAYLOAD = 1'b1
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic       first;
		logic [7:0] value;
		logic       last;
	} qitem_t;

	typedef struct packed {
		logic   push;
		qitem_t item;
	} qwrite_t;

	function automatic logic [39:0] fold(input logic [39:0] c, input logic [4:0] v);
		logic [4:0]  top;
		logic [39:0] r;
		top = c[39:35];
		r = {c[34:0], 5'b00000} ^ {35'd0, v};
		for (int i = 0; i < 5; i++) begin
			if (top[i]) begin
				r = r ^ GEN[i];
			end
		end
		return r;
	endfunction

	function automatic logic [7:0] symbol(input logic [4:0] g);
		logic [7:0] base;
		base = {~g, 3'b000};
		return SYMBOL_STR[base +: 8];
	endfunction

endpackage

/* hdl/caeu_front.sv */
module caeu_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_stall,
	input  logic             kind,
	input  logic [7:0]       value,
	input  logic             last,
	input  logic             q_full,
	output caeu_pkg::qwrite_t q_wr
);
	import caeu_pkg::*;

	logic  phase_q;
	logic  accept;
	kind_t item_kind;

	assign item_kind  = kind_t'(kind);
	assign item_stall = q_full;
	assign accept     = item_valid && !q_full;

	// A prefix character that turns up during the payload phase is dropped here.
	always_comb begin
		q_wr.push       = accept && !(item_kind == KIND_PREFIX && phase_q);
		q_wr.item.kind  = item_kind;
		q_wr.item.first = (item_kind == KIND_PAYLOAD) && !phase_q;
		q_wr.item.value = value;
		q_wr.item.last  = last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= 1'b0;
		end else if (accept && item_kind == KIND_PAYLOAD) begin
			phase_q <= !last;
		end
	end

endmodule

/* hdl/caeu_queue.sv */
module caeu_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  caeu_pkg::qwrite_t q_wr,
	input  logic              pop,
	output logic              head_valid,
	output caeu_pkg::qitem_t  head_item,
	output logic              full
);
	import caeu_pkg::*;

	qitem_t                 mem_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_W-1:0] wr_ptr_q;
	logic [QUEUE_PTR_W-1:0] rd_ptr_q;
	logic [QUEUE_CNT_W-1:0] count_q;
	logic                   do_push;
	logic                   do_pop;

	assign full       = (count_q == QUEUE_CNT_W'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_item  = mem_q[rd_ptr_q];
	assign do_push    = q_wr.push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= q_wr.item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* hdl/caeu_back.sv */
module caeu_back #(
	parameter int MAX_DATA_GROUPS = caeu_pkg::MAX_DATA_GROUPS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             head_valid,
	input  caeu_pkg::qitem_t head_item,
	output logic             pop,
	output logic             result_valid,
	input  logic             result_stall,
	output logic [7:0]       character,
	output logic             end_of_address,
	output logic             error
);
	import caeu_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_GROUP = 5'b00010,
		ST_PAD   = 5'b00100,
		ST_ZERO  = 5'b01000,
		ST_CHK   = 5'b10000
	} state_t;

	state_t                   state_q, state_d;
	logic [39:0]              csum_q, csum_d;
	logic [11:0]              acc_q, acc_d;
	logic [3:0]               bits_q, bits_d;
	logic                     last_q, last_d;
	logic [2:0]               cnt_q, cnt_d;
	logic [GROUP_COUNT_W-1:0] gc_q, gc_d;
	logic                     ov_q, ov_d;

	logic                     out_valid_q;
	logic [7:0]               char_q;
	logic                     eoa_q;
	logic                     err_q;

	logic                     out_free;
	logic                     emit;
	logic [7:0]               e_char;
	logic                     e_eoa;
	logic                     e_err;

	logic [11:0]              g_acc;
	logic [3:0]               g_bits;
	logic                     g_last;
	logic [3:0]               nb;
	logic [4:0]               grp;
	logic [11:0]              rem;
	logic [4:0]               pad;
	logic [4:0]               pg;
	logic [GROUP_COUNT_W-1:0] gc_inc;
	logic                     ov_pg;
	logic [39:0]              fold_pg;
	logic [39:0]              fold_zero;
	logic [39:0]              fold_pre;
	state_t                   next_after;

	assign out_free = !out_valid_q || !result_stall;

	always_comb begin
		g_acc  = (state_q == ST_IDLE) ? {acc_q[3:0], head_item.value} : acc_q;
		g_bits = (state_q == ST_IDLE) ? (bits_q + 4'd8) : bits_q;
		g_last = (state_q == ST_IDLE) ? head_item.last : last_q;
		nb     = g_bits - 4'd5;
		grp    = 5'(g_acc >> nb);
		rem    = g_acc & ((12'd1 << nb) - 12'd1);
		pad    = 5'({1'b0, acc_q[3:0]} << (3'd5 - bits_q[2:0]));
		pg     = (state_q == ST_PAD) ? pad : grp;
		gc_inc = (gc_q != GROUP_COUNT_MAX) ? (gc_q + 1'b1) : gc_q;
		ov_pg  = ov_q || (gc_inc > GROUP_COUNT_W'(MAX_DATA_GROUPS));
		fold_pg   = fold(csum_q, pg);
		fold_zero = fold(csum_q, 5'd0);
		fold_pre  = fold(csum_q, head_item.value[4:0]);
		if (nb >= 4'd5) begin
			next_after = ST_GROUP;
		end else if (g_last) begin
			next_after = (nb != 4'd0) ? ST_PAD : ST_ZERO;
		end else begin
			next_after = ST_IDLE;
		end
	end

	always_comb begin
		state_d = state_q;
		csum_d  = csum_q;
		acc_d   = acc_q;
		bits_d  = bits_q;
		last_d  = last_q;
		cnt_d   = cnt_q;
		gc_d    = gc_q;
		ov_d    = ov_q;
		pop     = 1'b0;
		emit    = 1'b0;
		e_char  = symbol(pg);
		e_eoa   = 1'b0;
		e_err   = ov_pg;
		case (state_q)
			ST_IDLE: begin
				if (head_valid && out_free) begin
					pop  = 1'b1;
					emit = 1'b1;
					if (head_item.kind == KIND_PREFIX) begin
						csum_d = fold_pre;
						e_char = head_item.value;
						e_err  = 1'b0;
					end else if (head_item.first) begin
						csum_d  = fold_zero;
						e_char  = SEPARATOR;
						e_err   = ov_q;
						acc_d   = g_acc;
						bits_d  = g_bits;
						last_d  = head_item.last;
						state_d = ST_GROUP;
					end else begin
						csum_d  = fold_pg;
						gc_d    = gc_inc;
						ov_d    = ov_pg;
						acc_d   = rem;
						bits_d  = nb;
						last_d  = head_item.last;
						cnt_d   = '0;
						state_d = next_after;
					end
				end
			end
			ST_GROUP: begin
				if (out_free) begin
					emit    = 1'b1;
					csum_d  = fold_pg;
					gc_d    = gc_inc;
					ov_d    = ov_pg;
					acc_d   = rem;
					bits_d  = nb;
					cnt_d   = '0;
					state_d = next_after;
				end
			end
			ST_PAD: begin
				if (out_free) begin
					emit    = 1'b1;
					csum_d  = fold_pg;
					gc_d    = gc_inc;
					ov_d    = ov_pg;
					acc_d   = '0;
					bits_d  = '0;
					cnt_d   = '0;
					state_d = ST_ZERO;
				end
			end
			ST_ZERO: begin
				csum_d = fold_zero;
				cnt_d  = cnt_q + 1'b1;
				if (cnt_q == STEP_LAST) begin
					csum_d  = fold_zero ^ 40'd1;
					state_d = ST_CHK;
				end
			end
			ST_CHK: begin
				if (out_free) begin
					emit   = 1'b1;
					e_char = symbol(csum_q[39:35]);
					e_eoa  = (cnt_q == STEP_LAST);
					e_err  = ov_q;
					csum_d = {csum_q[34:0], 5'b00000};
					cnt_d  = cnt_q + 1'b1;
					if (cnt_q == STEP_LAST) begin
						csum_d  = CHECKSUM_INIT;
						acc_d   = '0;
						bits_d  = '0;
						gc_d    = '0;
						ov_d    = 1'b0;
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			csum_q      <= CHECKSUM_INIT;
			acc_q       <= '0;
			bits_q      <= '0;
			last_q      <= 1'b0;
			cnt_q       <= '0;
			gc_q        <= '0;
			ov_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			csum_q  <= csum_d;
			acc_q   <= acc_d;
			bits_q  <= bits_d;
			last_q  <= last_d;
			cnt_q   <= cnt_d;
			gc_q    <= gc_d;
			ov_q    <= ov_d;
			if (out_free) begin
				out_valid_q <= emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && emit) begin
			char_q <= e_char;
			eoa_q  <= e_eoa;
			err_q  <= e_err;
		end
	end

	assign result_valid   = out_valid_q;
	assign character      = char_q;
	assign end_of_address = eoa_q;
	assign error          = err_q;

endmodule

/* hdl/cashaddr_address_encoder_unit.sv */
// Streaming base32 address encoder with a 40-bit polymod checksum.
// Input channel (item_valid/item_stall): one address arrives as prefix characters
// followed by payload bytes, the final payload byte flagged by last.
// Output channel (result_valid/result_stall): one ASCII character per transaction;
// end_of_address marks the final checksum character and error flags an address
// whose payload produced more data groups than MAX_DATA_GROUPS.
// Items pass through a two-entry queue into a sequencer that owns the checksum and
// emits at most one character per cycle, and none while the output register is stalled.
// A prefix character yields one character, a payload byte one per 5-bit group (one
// or two), the first payload byte one more for the separator, and the final byte adds
// a padding group if bits remain, eight checksum folding steps and eight checksum
// characters. The first character of a transaction passes through the queue and the
// output register before it appears.
// Reset empties the queue, sets the checksum to its initial value and clears all phase state; no output is valid.
// When the receiver stalls, the output register holds its character, the sequencer
// waits to emit, and the queue fills and then stalls the input channel.
module cashaddr_address_encoder_unit #(
	parameter int MAX_DATA_GROUPS = caeu_pkg::MAX_DATA_GROUPS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	output logic       item_stall,
	input  logic       kind,
	input  logic [7:0] value,
	input  logic       last,
	output logic       result_valid,
	input  logic       result_stall,
	output logic [7:0] character,
	output logic       end_of_address,
	output logic       error
);
	import caeu_pkg::*;

	qwrite_t q_wr;
	logic    q_full;
	logic    q_pop;
	logic    head_valid;
	qitem_t  head_item;

	caeu_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.kind       (kind),
		.value      (value),
		.last       (last),
		.q_full     (q_full),
		.q_wr       (q_wr)
	);

	caeu_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_wr       (q_wr),
		.pop        (q_pop),
		.head_valid (head_valid),
		.head_item  (head_item),
		.full       (q_full)
	);

	caeu_back #(
		.MAX_DATA_GROUPS (MAX_DATA_GROUPS)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.head_valid     (head_valid),
		.head_item      (head_item),
		.pop            (q_pop),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.character      (character),
		.end_of_address (end_of_address),
		.error          (error)
	);

endmodule

/* hdl/caeu_checker.sv */
module caeu_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       result_valid,
	input logic       result_stall,
	input logic [7:0] character,
	input logic       end_of_address,
	input logic       error
);

	a_idle_after_reset: assert property (@(posedge clk) disable iff (!arst_n)
		$past(!arst_n) |-> !result_valid)
		else $error("result valid straight after reset");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(character)
			&& $stable(end_of_address) && $stable(error))
		else $error("stalled result changed");

	a_error_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_stall && end_of_address |=> !(result_valid && error))
		else $error("error carried into the next address");

	a_error_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_stall && error && !end_of_address
			|=> !(result_valid && !error))
		else $error("error dropped within an address");

endmodule

bind cashaddr_address_encoder_unit caeu_checker u_caeu_checker (.*);
